// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the pressure trend tracker modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, idle during reset
`define PTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define PTT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/ptt_pkg.sv -----
// ----------------------------------------------------------------------------
// ptt_pkg
// Types and constants for the pressure trend tracker
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int DEFAULT_HISTORY_DEPTH = 64;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_UPDATE_INTERVAL = 2'd0;
  localparam logic [1:0] REG_RESTART_WINDOW  = 2'd1;
  localparam logic [1:0] REG_READY_SAMPLES   = 2'd2;
  localparam logic [1:0] REG_READY_CONSIST   = 2'd3;

  localparam logic [31:0] UPDATE_INTERVAL_RST = 32'd300000;
  localparam logic [31:0] RESTART_WINDOW_RST  = 32'd7200000;
  localparam logic [9:0]  READY_SAMPLES_RST   = 10'd6;
  localparam logic [9:0]  READY_CONSIST_RST   = 10'd3;

  localparam logic [9:0] CNT_MAX = 10'd999;

  // baseline age bands and thresholds
  localparam logic [31:0] AGE_BAND0 = 32'd600000;
  localparam logic [31:0] AGE_BAND1 = 32'd1800000;
  localparam logic [31:0] AGE_BAND2 = 32'd3600000;
  localparam logic signed [17:0] TH_BAND0 = 18'sd150;
  localparam logic signed [17:0] TH_BAND1 = 18'sd100;
  localparam logic signed [17:0] TH_BAND2 = 18'sd70;
  localparam logic signed [17:0] TH_BAND3 = 18'sd50;

  // arithmetic widths
  localparam int MUL_A_W = 80;
  localparam int MUL_B_W = 35;
  localparam int DIV_N_W = 80;
  localparam int DIV_D_W = 64;
  localparam int X_W     = 23;
  localparam int SX_W    = 35;
  localparam int SY_W    = 28;

  // floor(d / 1000) = (d * RECIP_1000) >> 41 for any 32-bit d
  localparam logic [31:0] RECIP_1000 = 32'd2199023256;
  // floor(v / 10000) = (v * RECIP_10000) >> 32 for v below 2^19
  localparam logic [18:0] RECIP_10000 = 19'd429497;

  localparam logic [15:0] RATE_SCALE = 16'd36000;
  localparam logic [20:0] RATE_SAT   = 21'd1000000;
  localparam logic [4:0]  QUOT_MAX   = 5'd27;

  // outlook constants, units of 1e-4
  localparam logic signed [31:0] Z_FALL   = 32'sd1300000;
  localparam logic signed [31:0] Z_RISE   = 32'sd1270000;
  localparam logic signed [31:0] Z_STEADY = 32'sd1440000;
  localparam logic signed [31:0] Z_MAX    = 32'sd260000;
  localparam logic [18:0]        Z_ROUND  = 19'd5000;

  typedef enum logic [3:0] {
    S_IDLE, S_EVAL, S_WALK, S_MUL_NXX, S_MUL_SXX, S_MUL_NXY, S_MUL_SXY, S_SIGN,
    S_DIV_Q, S_MUL_FRAC, S_DIV_FRAC, S_RATE, S_DIV_AVG, S_ZCALC, S_CODE, S_OUT
  } state_t;

endpackage

// ----- sv/ptt_mul.sv -----
// ----------------------------------------------------------------------------
// ptt_mul
// Shift-add multiplier, one bit of the second operand per cycle
// ----------------------------------------------------------------------------
module ptt_mul
  import ptt_pkg::*;
#(
  parameter int A_W = MUL_A_W,
  parameter int B_W = MUL_B_W
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [A_W-1:0] op_a,
  input  logic [B_W-1:0] op_b,
  output logic           busy,
  output logic           done,
  output logic [A_W-1:0] product
);

  localparam int CW = $clog2(B_W + 1);

  logic [A_W-1:0] a_sh;
  logic [B_W-1:0] b_sh;
  logic [CW-1:0]  cnt;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(B_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, product kept modulo 2^A_W
  always_ff @(posedge clk) begin
    if (start) begin
      product <= '0;
      a_sh    <= op_a;
      b_sh    <= op_b;
    end else if (busy) begin
      if (b_sh[0]) begin
        product <= product + a_sh;
      end
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
    end
  end

endmodule

// ----- sv/ptt_div.sv -----
// ----------------------------------------------------------------------------
// ptt_div
// Restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ptt_div
  import ptt_pkg::*;
#(
  parameter int N_W = DIV_N_W,
  parameter int D_W = DIV_D_W
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           busy,
  output logic           done,
  output logic [N_W-1:0] quotient,
  output logic [D_W-1:0] remainder
);

  localparam int CW = $clog2(N_W + 1);

  logic [D_W-1:0] dvs;
  logic [CW-1:0]  cnt;
  logic [D_W:0]   trial;

  assign trial = {remainder, quotient[N_W-1]};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(N_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift in one dividend bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        remainder <= D_W'(trial - {1'b0, dvs});
        quotient  <= {quotient[N_W-2:0], 1'b1};
      end else begin
        remainder <= trial[D_W-1:0];
        quotient  <= {quotient[N_W-2:0], 1'b0};
      end
    end
  end

  `include "assert_macros.svh"

  `PTT_ASSERT(a_div_start_busy, start |=> busy, "divider did not go busy after start")

endmodule

// ----- sv/pressure_trend_tracker.sv -----
// ----------------------------------------------------------------------------
// pressure_trend_tracker
// Pressure tendency tracker with least-squares slope and outlook code
// ----------------------------------------------------------------------------
//  channel   | dir | handshake                  | contents
//  s_*       | in  | s_tvalid / s_tready        | pressure sample, timestamp
//  m_*       | out | m_tvalid / m_tready        | trend, flags, slope, stats, code
//  apb       | in  | psel, penable, pwrite      | four config registers, 4-byte stride
//
// An item without evaluation passes S_EVAL, S_ZCALC, S_CODE and S_OUT before s_tready returns.
// An evaluating item with two or more stored samples walks the history memory, then runs
// four products on the shared shift-add multiplier (one more for the fraction) and up to
// three divides on the serial divider.
// Reset is synchronous; the history memory has no reset, only filled entries are read.
// A finished result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module pressure_trend_tracker
  import ptt_pkg::*;
#(
  parameter int HISTORY_DEPTH = DEFAULT_HISTORY_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // pressure_sample[16:0], time_now_ms[48:17], zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // trend[1:0], trend_settled[2], forecast_code[7:3],
                                 // slope_rate[28:8], history_min[45:29],
                                 // history_max[62:46], history_avg[79:63],
                                 // alert_event[81:80], zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW  = $clog2(HISTORY_DEPTH);
  localparam int FW  = $clog2(HISTORY_DEPTH + 1);
  localparam int MW  = 17 + 32;

  // config registers
  logic [31:0] update_interval_ms;
  logic [31:0] restart_window_ms;
  logic [9:0]  ready_min_samples;
  logic [9:0]  ready_min_consistent;

  // tracker state
  logic              baseline_valid;
  logic [16:0]       baseline_pressure;
  logic [31:0]       baseline_start_ms;
  logic [31:0]       last_eval_ms;
  logic signed [1:0] current_trend;
  logic [9:0]        eval_count;
  logic [9:0]        consistent_count;
  logic              ready_flag;
  logic [AW-1:0]     ring_head;
  logic [FW-1:0]     ring_fill;
  logic signed [20:0] rate_value;
  logic [16:0]       min_value;
  logic [16:0]       max_value;
  logic [16:0]       avg_value;
  logic signed [1:0] alert;

  state_t state, state_next;

  logic [16:0] in_p;
  logic [31:0] in_t;

  // history memory: {pressure, time}
  logic [MW-1:0] ring_mem [HISTORY_DEPTH];
  logic          wr_en;
  logic [MW-1:0] mem_q;
  logic          rd_en;
  logic [AW-1:0] rd_ptr;

  // walk pipeline
  logic [FW-1:0]     issue_cnt;
  logic [FW-1:0]     acc_cnt;
  logic              v1, f1, v2, v3;
  logic [31:0]       t0;
  logic [X_W-1:0]    x2, x3;
  logic [16:0]       y2, y3;
  logic [39:0]       xy3;
  logic [45:0]       xx3;
  logic [SX_W-1:0]   sum_x;
  logic [SY_W-1:0]   sum_y;
  logic [63:0]       sum_xy;
  logic [63:0]       sum_xx;
  logic [31:0]       diff_t;
  logic [63:0]       xprod;

  // solve registers
  logic [63:0] p_nxx, p_sxx, p_nxy, p_sxy;
  logic [63:0] den, mag;
  logic        neg;
  logic [4:0]  q_int;
  logic [63:0] q_rem;
  logic [15:0] q_frac;
  logic signed [31:0] z_reg;
  logic [4:0]  code_reg;
  logic        launched;

  // shared units
  logic               mul_start, mul_busy, mul_done;
  logic [MUL_A_W-1:0] mul_a, mul_p;
  logic [MUL_B_W-1:0] mul_b;
  logic               div_start, div_busy, div_done;
  logic [DIV_N_W-1:0] div_n, div_q;
  logic [DIV_D_W-1:0] div_d, div_r;

  // eval decode
  logic              accept;
  logic              do_push;
  logic              do_eval;
  logic [31:0]       elapsed;
  logic signed [17:0] pdiff;
  logic signed [17:0] th;
  logic signed [1:0] nt;
  logic [9:0]        eval_next;
  logic [9:0]        cons_next;
  logic [AW-1:0]     head_next;
  logic [FW-1:0]     fill_next;
  logic [63:0]       den_calc, num_calc;
  logic [20:0]       rate_mag;
  logic [20:0]       kp;
  logic signed [27:0] rate45;
  logic signed [31:0] z_base;
  logic signed [31:0] z_calc;
  logic [18:0]       z_clamp;
  logic [37:0]       code_prod;
  logic              out_load;

  assign accept = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign pready = 1'b1;

  // config writes and reads
  always_ff @(posedge clk) begin
    if (rst) begin
      update_interval_ms   <= UPDATE_INTERVAL_RST;
      restart_window_ms    <= RESTART_WINDOW_RST;
      ready_min_samples    <= READY_SAMPLES_RST;
      ready_min_consistent <= READY_CONSIST_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_UPDATE_INTERVAL: update_interval_ms   <= pwdata;
        REG_RESTART_WINDOW:  restart_window_ms    <= pwdata;
        REG_READY_SAMPLES:   ready_min_samples    <= pwdata[9:0];
        REG_READY_CONSIST:   ready_min_consistent <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_UPDATE_INTERVAL: prdata = update_interval_ms;
      REG_RESTART_WINDOW:  prdata = restart_window_ms;
      REG_READY_SAMPLES:   prdata = {22'd0, ready_min_samples};
      REG_READY_CONSIST:   prdata = {22'd0, ready_min_consistent};
      default:             prdata = '0;
    endcase
  end

  // input capture
  always_ff @(posedge clk) begin
    if (accept) begin
      in_p <= s_tdata[16:0];
      in_t <= s_tdata[48:17];
    end
  end

  // evaluation decode
  always_comb begin
    do_eval = baseline_valid && ((in_t - last_eval_ms) > update_interval_ms);
    do_push = !baseline_valid || do_eval;
    elapsed = in_t - baseline_start_ms;
    pdiff   = $signed({1'b0, in_p}) - $signed({1'b0, baseline_pressure});
    if (elapsed < AGE_BAND0) begin
      th = TH_BAND0;
    end else if (elapsed < AGE_BAND1) begin
      th = TH_BAND1;
    end else if (elapsed < AGE_BAND2) begin
      th = TH_BAND2;
    end else begin
      th = TH_BAND3;
    end
    if (pdiff >= th) begin
      nt = 2'sd1;
    end else if (pdiff <= -th) begin
      nt = -2'sd1;
    end else begin
      nt = 2'sd0;
    end
    eval_next = (eval_count < CNT_MAX) ? eval_count + 1'b1 : eval_count;
    if (nt != 2'sd0 && nt == current_trend) begin
      cons_next = (consistent_count < CNT_MAX) ? consistent_count + 1'b1 : consistent_count;
    end else if (nt == 2'sd0) begin
      cons_next = '0;
    end else begin
      cons_next = 10'd1;
    end
    head_next = (ring_head == AW'(HISTORY_DEPTH - 1)) ? '0 : ring_head + 1'b1;
    fill_next = (ring_fill < FW'(HISTORY_DEPTH)) ? ring_fill + 1'b1 : ring_fill;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  // next state and shared unit requests
  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_n      = '0;
    div_d      = '0;
    unique case (state)
      S_IDLE: if (accept) state_next = S_EVAL;
      S_EVAL: begin
        if (!do_push || fill_next < FW'(2)) begin
          state_next = S_ZCALC;
        end else begin
          state_next = S_WALK;
        end
      end
      S_WALK: if (acc_cnt == ring_fill) state_next = S_MUL_NXX;
      S_MUL_NXX: begin
        mul_start = !launched;
        mul_a     = MUL_A_W'(sum_xx);
        mul_b     = MUL_B_W'(ring_fill);
        if (mul_done) state_next = S_MUL_SXX;
      end
      S_MUL_SXX: begin
        mul_start = !launched;
        mul_a     = MUL_A_W'(sum_x);
        mul_b     = MUL_B_W'(sum_x);
        if (mul_done) state_next = S_MUL_NXY;
      end
      S_MUL_NXY: begin
        mul_start = !launched;
        mul_a     = MUL_A_W'(sum_xy);
        mul_b     = MUL_B_W'(ring_fill);
        if (mul_done) state_next = S_MUL_SXY;
      end
      S_MUL_SXY: begin
        mul_start = !launched;
        mul_a     = MUL_A_W'(sum_y);
        mul_b     = MUL_B_W'(sum_x);
        if (mul_done) state_next = S_SIGN;
      end
      S_SIGN: state_next = (den_calc == '0) ? S_DIV_AVG : S_DIV_Q;
      S_DIV_Q: begin
        div_start = !launched;
        div_n     = DIV_N_W'(mag);
        div_d     = den;
        if (div_done) begin
          state_next = (div_q > DIV_N_W'(QUOT_MAX)) ? S_DIV_AVG : S_MUL_FRAC;
        end
      end
      S_MUL_FRAC: begin
        mul_start = !launched;
        mul_a     = MUL_A_W'(q_rem);
        mul_b     = MUL_B_W'(RATE_SCALE);
        if (mul_done) state_next = S_DIV_FRAC;
      end
      S_DIV_FRAC: begin
        div_start = !launched;
        div_n     = mul_p;
        div_d     = den;
        if (div_done) state_next = S_RATE;
      end
      S_RATE: state_next = S_DIV_AVG;
      S_DIV_AVG: begin
        div_start = !launched;
        div_n     = DIV_N_W'(sum_y);
        div_d     = DIV_D_W'(ring_fill);
        if (div_done) state_next = S_ZCALC;
      end
      S_ZCALC: state_next = S_CODE;
      S_CODE:  state_next = S_OUT;
      S_OUT:   if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // one launch per unit operation
  always_ff @(posedge clk) begin
    if (rst) begin
      launched <= 1'b0;
    end else if (mul_start || div_start) begin
      launched <= 1'b1;
    end else if (mul_done || div_done) begin
      launched <= 1'b0;
    end
  end

  // tracker state update
  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_valid    <= 1'b0;
      baseline_pressure <= '0;
      baseline_start_ms <= '0;
      last_eval_ms      <= '0;
      current_trend     <= '0;
      eval_count        <= '0;
      consistent_count  <= '0;
      ready_flag        <= 1'b0;
      ring_head         <= '0;
      ring_fill         <= '0;
      rate_value        <= '0;
      min_value         <= '0;
      max_value         <= '0;
      avg_value         <= '0;
      alert             <= '0;
    end else begin
      if (state == S_EVAL) begin
        alert <= '0;
        if (!baseline_valid) begin
          baseline_valid    <= 1'b1;
          baseline_pressure <= in_p;
          baseline_start_ms <= in_t;
          last_eval_ms      <= in_t;
          current_trend     <= '0;
        end else if (do_eval) begin
          eval_count       <= eval_next;
          consistent_count <= cons_next;
          ready_flag       <= (eval_next >= ready_min_samples) &&
                              (cons_next >= ready_min_consistent);
          if (nt != current_trend && nt != 2'sd0) alert <= nt;
          current_trend <= nt;
          if (elapsed > restart_window_ms) begin
            baseline_pressure <= in_p;
            baseline_start_ms <= in_t;
          end
          last_eval_ms <= in_t;
        end
        if (do_push) begin
          ring_head <= head_next;
          ring_fill <= fill_next;
          min_value <= in_p;
          max_value <= in_p;
          if (fill_next < FW'(2)) begin
            rate_value <= '0;
            avg_value  <= in_p;
          end
        end
      end
      // min and max follow the walk
      if (v1) begin
        if (mem_q[MW-1:32] < min_value) min_value <= mem_q[MW-1:32];
        if (mem_q[MW-1:32] > max_value) max_value <= mem_q[MW-1:32];
      end
      if (state == S_DIV_Q && div_done && div_q > DIV_N_W'(QUOT_MAX)) begin
        rate_value <= neg ? -$signed(RATE_SAT) : $signed(RATE_SAT);
      end
      if (state == S_RATE) begin
        rate_value <= neg ? -$signed(rate_mag) : $signed(rate_mag);
      end
      if (state == S_DIV_AVG && div_done) begin
        avg_value <= div_q[16:0];
      end
    end
  end

  // history memory write and read
  assign wr_en = (state == S_EVAL) && do_push;
  assign rd_en = (state == S_WALK) && (issue_cnt < ring_fill);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[ring_head] <= {in_p, in_t};
    end
    if (rd_en) begin
      mem_q <= ring_mem[rd_ptr];
    end
  end

  // walk issue and pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      f1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      issue_cnt <= '0;
      acc_cnt   <= '0;
      rd_ptr    <= '0;
    end else begin
      v1 <= rd_en;
      f1 <= rd_en && (issue_cnt == '0);
      v2 <= v1;
      v3 <= v2;
      if (state == S_EVAL) begin
        issue_cnt <= '0;
        acc_cnt   <= '0;
        rd_ptr    <= (fill_next < FW'(HISTORY_DEPTH)) ? '0 : head_next;
      end else begin
        if (rd_en) begin
          issue_cnt <= issue_cnt + 1'b1;
          rd_ptr    <= (rd_ptr == AW'(HISTORY_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
        end
        if (v3) acc_cnt <= acc_cnt + 1'b1;
      end
    end
  end

  // seconds from the oldest entry, products, sums
  assign diff_t = f1 ? '0 : mem_q[31:0] - t0;
  assign xprod  = diff_t * RECIP_1000;

  always_ff @(posedge clk) begin
    if (v1) begin
      if (f1) t0 <= mem_q[31:0];
      x2 <= xprod[63:41];
      y2 <= mem_q[MW-1:32];
    end
    x3  <= x2;
    y3  <= y2;
    xy3 <= 40'(x2) * 40'(y2);
    xx3 <= 46'(x2) * 46'(x2);
    if (state == S_EVAL) begin
      sum_x  <= '0;
      sum_y  <= '0;
      sum_xy <= '0;
      sum_xx <= '0;
    end else if (v3) begin
      sum_x  <= sum_x + SX_W'(x3);
      sum_y  <= sum_y + SY_W'(y3);
      sum_xy <= sum_xy + 64'(xy3);
      sum_xx <= sum_xx + 64'(xx3);
    end
  end

  // slope solve
  assign den_calc = p_nxx - p_sxx;
  assign num_calc = p_nxy - p_sxy;

  always_comb begin
    rate_mag = 21'(q_int) * 21'(RATE_SCALE) + 21'(q_frac);
    if (rate_mag > RATE_SAT) rate_mag = RATE_SAT;
  end

  always_ff @(posedge clk) begin
    if (mul_done) begin
      case (state)
        S_MUL_NXX: p_nxx <= mul_p[63:0];
        S_MUL_SXX: p_sxx <= mul_p[63:0];
        S_MUL_NXY: p_nxy <= mul_p[63:0];
        S_MUL_SXY: p_sxy <= mul_p[63:0];
        default: ;
      endcase
    end
    if (state == S_SIGN) begin
      den <= den_calc;
      neg <= num_calc[63];
      mag <= num_calc[63] ? -num_calc : num_calc;
    end
    if (state == S_DIV_Q && div_done) begin
      q_int <= div_q[4:0];
      q_rem <= div_r;
    end
    if (state == S_DIV_FRAC && div_done) begin
      q_frac <= div_q[15:0];
    end
  end

  // outlook code
  always_comb begin
    if (current_trend < 0) begin
      z_base = Z_FALL;
      kp     = 21'(in_p) * 21'd12;
    end else if (current_trend > 0) begin
      z_base = Z_RISE;
      kp     = 21'(in_p) * 21'd12;
    end else begin
      z_base = Z_STEADY;
      kp     = 21'(in_p) * 21'd13;
    end
    rate45 = 28'(rate_value) * 28'sd45;
    z_calc = z_base - $signed({11'd0, kp}) - 32'(rate45);
    if (z_reg < 0) begin
      z_clamp = '0;
    end else if (z_reg > Z_MAX) begin
      z_clamp = 19'(Z_MAX);
    end else begin
      z_clamp = z_reg[18:0];
    end
    code_prod = 38'(z_clamp + Z_ROUND) * 38'(RECIP_10000);
  end

  always_ff @(posedge clk) begin
    if (state == S_ZCALC) z_reg <= z_calc;
    if (state == S_CODE) code_reg <= code_prod[36:32];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {6'd0, alert, avg_value, max_value, min_value, rate_value,
                  code_reg, ready_flag, current_trend};
    end
  end

  // shared units
  ptt_mul #(.A_W(MUL_A_W), .B_W(MUL_B_W)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .busy    (mul_busy),
    .done    (mul_done),
    .product (mul_p)
  );

  ptt_div #(.N_W(DIV_N_W), .D_W(DIV_D_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_n),
    .divisor   (div_d),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  `include "assert_macros.svh"

  `PTT_ASSERT(a_accept_blocks, (s_tvalid && s_tready) |=> !s_tready, "item taken while busy")
  `PTT_ASSERT(a_walk_bound, (state == S_WALK) |-> (acc_cnt <= ring_fill), "walk overran fill")
  `PTT_ASSERT(a_unit_idle, !(mul_start && mul_busy) && !(div_start && div_busy), "unit restarted while busy")
  `PTT_ASSERT_ALWAYS(a_out_load, out_load |=> (m_tvalid || rst), "result not presented")

endmodule
